@@ rtl/assert_macros.svh @@
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/dda_pkg.sv @@
package dda_pkg;

    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/dda_div.sv @@
module dda_div
    import dda_pkg::*;
#(
    parameter int DW = 10,
    parameter int QW = DEF_FRAC_BITS + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [DW-1:0] mag,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient,
    output div_stat_t     stat
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic          bin_reg, bin_next;
    logic [DW-1:0] div_reg, div_next;
    logic [QW-1:0] quo_reg, quo_next;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // one restoring step: shift in a dividend bit, subtract if it fits
    assign trial = {rem_reg, bin_reg};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bin_next  = bin_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (load)
        begin
            rem_next  = mag >> 1;
            bin_next  = mag[0];
            div_next  = divisor;
            quo_next  = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            bin_next = 1'b0;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        bin_reg <= bin_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/dda_line_rasterizer_top.sv @@
// channel | valid      | stall       | word fields
// item    | item_valid | item_stall  | kind, start_x, start_y, end_x, end_y
// point   | point_valid| point_stall | point_x, point_y, last_point
//
// ticks stream at one per cycle while point flows and the divider is idle
// a start word emits its start point at once; for a line of nonzero length the
// shared divider then forms both increments, the x axis first, then the y axis
// item_stall is high while the divider runs and while a point waits on point_stall
// rst_n clears the sequencer, line state and the point valid flag asynchronously
`include "assert_macros.svh"

module dda_line_rasterizer_top
    import dda_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             kind,
    input  logic [$clog2(SCREEN_WIDTH)-1:0]  start_x,
    input  logic [$clog2(SCREEN_HEIGHT)-1:0] start_y,
    input  logic [$clog2(SCREEN_WIDTH)-1:0]  end_x,
    input  logic [$clog2(SCREEN_HEIGHT)-1:0] end_y,
    output logic                             point_valid,
    input  logic                             point_stall,
    output logic [$clog2(SCREEN_WIDTH)-1:0]  point_x,
    output logic [$clog2(SCREEN_HEIGHT)-1:0] point_y,
    output logic                             last_point
);

    localparam int XW  = $clog2(SCREEN_WIDTH);
    localparam int YW  = $clog2(SCREEN_HEIGHT);
    localparam int DW  = (XW > YW) ? XW : YW;
    localparam int XAW = XW + FRAC_BITS;
    localparam int YAW = YW + FRAC_BITS;
    localparam int QW  = FRAC_BITS + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIVX = 2'd1;
    localparam logic [1:0] ST_DIVY = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic           line_active_reg, line_active_next;
    logic [DW-1:0]  points_left_reg, points_left_next;
    logic           point_valid_reg, point_valid_next;

    logic [XAW-1:0] x_accum_reg, x_accum_next;
    logic [YAW-1:0] y_accum_reg, y_accum_next;
    logic [XAW-1:0] x_step_reg, x_step_next;
    logic [YAW-1:0] y_step_reg, y_step_next;
    logic [DW-1:0]  steps_reg, steps_next;
    logic [DW-1:0]  dy_mag_reg, dy_mag_next;
    logic           x_neg_reg, x_neg_next;
    logic           y_neg_reg, y_neg_next;
    logic [XW-1:0]  point_x_reg, point_x_next;
    logic [YW-1:0]  point_y_reg, point_y_next;
    logic           last_point_reg, last_point_next;

    logic           item_accept;
    logic [XW:0]    dx;
    logic [YW:0]    dy;
    logic [XW:0]    dx_abs;
    logic [YW:0]    dy_abs;
    logic [DW-1:0]  dx_mag;
    logic [DW-1:0]  dy_mag;
    logic [DW-1:0]  steps_in;
    logic           start_go;

    logic           div_load;
    logic [DW-1:0]  div_mag;
    logic [DW-1:0]  div_divisor;
    logic [QW-1:0]  div_quotient;
    div_stat_t      div_stat;

    logic [XAW-1:0] x_q;
    logic [YAW-1:0] y_q;

    assign item_stall  = (state_reg != ST_IDLE) || (point_valid_reg && point_stall);
    assign item_accept = item_valid && !item_stall;

    assign dx       = {1'b0, end_x} - {1'b0, start_x};
    assign dy       = {1'b0, end_y} - {1'b0, start_y};
    assign dx_abs   = dx[XW] ? -dx : dx;
    assign dy_abs   = dy[YW] ? -dy : dy;
    assign dx_mag   = DW'(dx_abs[XW-1:0]);
    assign dy_mag   = DW'(dy_abs[YW-1:0]);
    assign steps_in = (dx_mag > dy_mag) ? dx_mag : dy_mag;
    assign start_go = item_accept && !kind && (steps_in != '0);

    assign div_load    = start_go || ((state_reg == ST_DIVX) && div_stat.done);
    assign div_mag     = (state_reg == ST_IDLE) ? dx_mag : dy_mag_reg;
    assign div_divisor = (state_reg == ST_IDLE) ? steps_in : steps_reg;

    assign x_q = XAW'(div_quotient);
    assign y_q = YAW'(div_quotient);

    dda_div #(
        .DW (DW),
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .mag      (div_mag),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        line_active_next = line_active_reg;
        points_left_next = points_left_reg;
        point_valid_next = point_valid_reg;
        x_accum_next     = x_accum_reg;
        y_accum_next     = y_accum_reg;
        x_step_next      = x_step_reg;
        y_step_next      = y_step_reg;
        steps_next       = steps_reg;
        dy_mag_next      = dy_mag_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        point_x_next     = point_x_reg;
        point_y_next     = point_y_reg;
        last_point_next  = last_point_reg;

        if (point_valid_reg && !point_stall)
        begin
            point_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && !kind)
                begin
                    x_accum_next     = {start_x, {FRAC_BITS{1'b0}}};
                    y_accum_next     = {start_y, {FRAC_BITS{1'b0}}};
                    x_step_next      = '0;
                    y_step_next      = '0;
                    steps_next       = steps_in;
                    dy_mag_next      = dy_mag;
                    x_neg_next       = dx[XW];
                    y_neg_next       = dy[YW];
                    points_left_next = steps_in;
                    line_active_next = 1'b0;
                    point_x_next     = start_x;
                    point_y_next     = start_y;
                    last_point_next  = (steps_in == '0);
                    point_valid_next = 1'b1;
                    if (steps_in != '0)
                    begin
                        state_next = ST_DIVX;
                    end
                end
                else if (item_accept && line_active_reg)
                begin
                    x_accum_next     = x_accum_reg + x_step_reg;
                    y_accum_next     = y_accum_reg + y_step_reg;
                    points_left_next = points_left_reg - 1'b1;
                    line_active_next = (points_left_reg != DW'(1));
                    point_x_next     = x_accum_next[XAW-1:FRAC_BITS];
                    point_y_next     = y_accum_next[YAW-1:FRAC_BITS];
                    last_point_next  = (points_left_reg == DW'(1));
                    point_valid_next = 1'b1;
                end
            end
            ST_DIVX:
            begin
                if (div_stat.done)
                begin
                    x_step_next = x_neg_reg ? -x_q : x_q;
                    state_next  = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_stat.done)
                begin
                    y_step_next      = y_neg_reg ? -y_q : y_q;
                    line_active_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            points_left_reg <= '0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_active_reg <= line_active_next;
            points_left_reg <= points_left_next;
            point_valid_reg <= point_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_accum_reg    <= x_accum_next;
        y_accum_reg    <= y_accum_next;
        x_step_reg     <= x_step_next;
        y_step_reg     <= y_step_next;
        steps_reg      <= steps_next;
        dy_mag_reg     <= dy_mag_next;
        x_neg_reg      <= x_neg_next;
        y_neg_reg      <= y_neg_next;
        point_x_reg    <= point_x_next;
        point_y_reg    <= point_y_next;
        last_point_reg <= last_point_next;
    end

    assign point_valid = point_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign last_point  = last_point_reg;

    `ASSERT_SAME(a_accept_idle, item_accept, state_reg == ST_IDLE)
    `ASSERT_SAME(a_div_busy_state, div_stat.busy || div_stat.done, state_reg != ST_IDLE)
    `ASSERT_SAME(a_active_has_points, line_active_reg, points_left_reg != '0)
    `ASSERT_NEXT(a_start_emits, start_go, point_valid_reg && !last_point_reg && state_reg == ST_DIVX)

endmodule
